FILE: rtl/qacd_pkg.sv
package qacd_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int ACCEL_W         = 12;
    localparam int ACCEL_TOP       = 3072;
    localparam int ACCEL_RISE      = 80;
    localparam int ACCEL_DEC       = 2;
    localparam int ACCEL_SHIFT     = 6;
    localparam int STEP_W          = 7;
    localparam int EVENT_W         = 3;
    localparam int KEY_W           = 16;
    localparam int INTERVAL_W      = 8;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;
    localparam int REG_IDX_W       = 3;

    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_TAKE_ROT  = 2'd1;
    localparam logic [1:0] OP_TAKE_BTN  = 2'd2;

    localparam logic [EVENT_W-1:0] EV_OPEN     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_CLICKED  = 3'd1;
    localparam logic [EVENT_W-1:0] EV_DOUBLE   = 3'd2;
    localparam logic [EVENT_W-1:0] EV_HELD     = 3'd3;
    localparam logic [EVENT_W-1:0] EV_LONG     = 3'd4;
    localparam logic [EVENT_W-1:0] EV_RELEASED = 3'd5;

    localparam logic [REG_IDX_W-1:0] REG_HALF_STEP    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FEATURES     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BTN_PRESENT  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CHECK_IVAL   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HOLD         = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LONG_HOLD    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DOUBLE_CLICK = 3'd6;

    localparam int FEAT_ACCEL  = 0;
    localparam int FEAT_DOUBLE = 1;
    localparam int FEAT_HELD   = 2;

    typedef struct packed {
        logic [1:0] opcode;
        logic       pin_a;
        logic       pin_b;
        logic       button_level;
    } t_in_item;

    typedef struct packed {
        logic signed [STEP_W-1:0]  rotation_steps;
        logic        [EVENT_W-1:0] button_event;
    } t_out_item;

    typedef struct packed {
        logic                  half_step;
        logic [2:0]            feature_enables;
        logic                  button_present;
        logic [INTERVAL_W-1:0] check_interval;
        logic [KEY_W-1:0]      hold_checks;
        logic [KEY_W-1:0]      long_hold_checks;
        logic [KEY_W-1:0]      double_click_checks;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        half_step:           1'b0,
        feature_enables:     3'd7,
        button_present:      1'b1,
        check_interval:      8'd10,
        hold_checks:         16'd100,
        long_hold_checks:    16'd300,
        double_click_checks: 16'd50
    };

endpackage

FILE: rtl/quadrature_accel_and_click_detector.sv
// Quadrature encoder with rotation acceleration and a click / double click /
// held / long held / released button detector. Every input transaction (tick,
// take rotation or take button event) yields exactly one result transaction.
// A transaction can be accepted in every cycle unless the receiver holds back
// results; it is captured in the input register, and its result is computed
// in the single logic stage that updates all state and is then captured in
// the output register. A result held back by the receiver stops input only
// once the input register is full as well.
// Configuration registers sit on the APB port at byte addresses 4*i and should
// be written only while no transaction is in flight.
module quadrature_accel_and_click_detector #(
    parameter int COUNT_WIDTH = qacd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  qacd_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output qacd_pkg::t_out_item           o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qacd_pkg::ADDR_W-1:0]   paddr,
    input  logic [qacd_pkg::DATA_W-1:0]   pwdata,
    output logic [qacd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    qacd_pkg::t_cfg      cfg;
    qacd_pkg::t_in_item  r_in;
    logic                r_in_valid;
    qacd_pkg::t_out_item r_out, n_out;
    logic                r_out_valid;

    logic                                   advance;
    logic                                   do_tick;
    logic                                   do_rot;
    logic                                   do_btn;
    logic signed [qacd_pkg::STEP_W-1:0]     steps;
    logic                                   notch;
    logic [qacd_pkg::EVENT_W-1:0]           event_code;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign do_tick    = advance && (r_in.opcode == qacd_pkg::OP_TICK);
    assign do_rot     = advance && (r_in.opcode == qacd_pkg::OP_TAKE_ROT);
    assign do_btn     = advance && (r_in.opcode == qacd_pkg::OP_TAKE_BTN);

    qacd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    qacd_enc #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_enc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (do_tick),
        .i_take  (do_rot),
        .i_pin_a (r_in.pin_a),
        .i_pin_b (r_in.pin_b),
        .i_cfg   (cfg),
        .o_steps (steps),
        .o_notch (notch)
    );

    qacd_btn u_btn (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (do_tick),
        .i_take         (do_btn),
        .i_clr_key      (do_rot && notch),
        .i_button_level (r_in.button_level),
        .i_cfg          (cfg),
        .o_event        (event_code)
    );

    always_comb begin
        n_out = '0;
        unique case (r_in.opcode)
            qacd_pkg::OP_TAKE_ROT: n_out.rotation_steps = steps;
            qacd_pkg::OP_TAKE_BTN: n_out.button_event   = event_code;
            default:               n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_in <= i_in_item;
        if (advance) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: rtl/qacd_regs.sv
module qacd_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qacd_pkg::ADDR_W-1:0]   paddr,
    input  logic [qacd_pkg::DATA_W-1:0]   pwdata,
    output logic [qacd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output qacd_pkg::t_cfg                o_cfg
);

    qacd_pkg::t_cfg                      r_cfg;
    qacd_pkg::t_cfg                      n_cfg;
    logic [qacd_pkg::REG_IDX_W-1:0]      idx;
    logic                                wr_en;

    assign idx    = paddr[qacd_pkg::ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (idx)
                qacd_pkg::REG_HALF_STEP:    n_cfg.half_step           = pwdata[0];
                qacd_pkg::REG_FEATURES:     n_cfg.feature_enables     = pwdata[2:0];
                qacd_pkg::REG_BTN_PRESENT:  n_cfg.button_present      = pwdata[0];
                qacd_pkg::REG_CHECK_IVAL:   n_cfg.check_interval      = pwdata[7:0];
                qacd_pkg::REG_HOLD:         n_cfg.hold_checks         = pwdata[15:0];
                qacd_pkg::REG_LONG_HOLD:    n_cfg.long_hold_checks    = pwdata[15:0];
                qacd_pkg::REG_DOUBLE_CLICK: n_cfg.double_click_checks = pwdata[15:0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= qacd_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (idx)
            qacd_pkg::REG_HALF_STEP:    prdata = 32'(r_cfg.half_step);
            qacd_pkg::REG_FEATURES:     prdata = 32'(r_cfg.feature_enables);
            qacd_pkg::REG_BTN_PRESENT:  prdata = 32'(r_cfg.button_present);
            qacd_pkg::REG_CHECK_IVAL:   prdata = 32'(r_cfg.check_interval);
            qacd_pkg::REG_HOLD:         prdata = 32'(r_cfg.hold_checks);
            qacd_pkg::REG_LONG_HOLD:    prdata = 32'(r_cfg.long_hold_checks);
            qacd_pkg::REG_DOUBLE_CLICK: prdata = 32'(r_cfg.double_click_checks);
            default:                    prdata = '0;
        endcase
    end

endmodule

FILE: rtl/qacd_enc.sv
module qacd_enc #(
    parameter int COUNT_WIDTH = qacd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_tick,
    input  logic                                  i_take,
    input  logic                                  i_pin_a,
    input  logic                                  i_pin_b,
    input  qacd_pkg::t_cfg                        i_cfg,
    output logic signed [qacd_pkg::STEP_W-1:0]    o_steps,
    output logic                                  o_notch
);

    localparam int AW = qacd_pkg::ACCEL_W;
    localparam int SW = qacd_pkg::STEP_W;
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    logic [1:0]                    r_phase, n_phase;
    logic signed [COUNT_WIDTH-1:0] r_count, n_count;
    logic [AW-1:0]                 r_accel, n_accel;

    logic [1:0]    curr;
    logic [1:0]    diff;
    logic [AW-1:0] accel_dec;
    logic [AW-1:0] inc;
    logic [SW-1:0] mag;

    assign curr[1]   = ~i_pin_a;
    assign curr[0]   = i_pin_a ^ i_pin_b;
    assign diff      = r_phase - curr;
    assign accel_dec = (r_accel < AW'(qacd_pkg::ACCEL_DEC)) ? '0
                       : r_accel - AW'(qacd_pkg::ACCEL_DEC);
    assign inc       = i_cfg.half_step ? AW'(qacd_pkg::ACCEL_RISE / 2)
                                       : AW'(qacd_pkg::ACCEL_RISE);

    // whole notches present: quotient of floor division is nonzero
    assign o_notch = i_cfg.half_step ? (|r_count[COUNT_WIDTH-1:1])
                                     : (|r_count[COUNT_WIDTH-1:2]);

    assign mag = SW'(1) + (i_cfg.feature_enables[qacd_pkg::FEAT_ACCEL]
                 ? SW'(r_accel[AW-1:qacd_pkg::ACCEL_SHIFT]) : SW'(0));

    always_comb begin
        if (!o_notch) begin
            o_steps = '0;
        end else if (r_count[COUNT_WIDTH-1]) begin
            o_steps = -$signed(mag);
        end else begin
            o_steps = $signed(mag);
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_accel = r_accel;
        if (i_tick) begin
            n_accel = accel_dec;
            if (diff[0]) begin
                n_phase = curr;
                if (diff[1]) begin
                    if (r_count != CNT_MAX) n_count = r_count + 1'b1;
                end else begin
                    if (r_count != CNT_MIN) n_count = r_count - 1'b1;
                end
                if (accel_dec <= AW'(qacd_pkg::ACCEL_TOP) - inc) begin
                    n_accel = accel_dec + inc;
                end
            end
        end else if (i_take) begin
            if (i_cfg.half_step) begin
                n_count = {{(COUNT_WIDTH-1){1'b0}}, r_count[0]};
            end else begin
                n_count = {{(COUNT_WIDTH-2){1'b0}}, r_count[1:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_count <= '0;
            r_accel <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_accel <= n_accel;
        end
    end

endmodule

FILE: rtl/qacd_btn.sv
module qacd_btn (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_tick,
    input  logic                               i_take,
    input  logic                               i_clr_key,
    input  logic                               i_button_level,
    input  qacd_pkg::t_cfg                     i_cfg,
    output logic [qacd_pkg::EVENT_W-1:0]       o_event
);

    localparam int KW = qacd_pkg::KEY_W;
    localparam int IW = qacd_pkg::INTERVAL_W;

    logic [KW-1:0]                 r_key, n_key;
    logic [KW-1:0]                 r_dbl, n_dbl;
    logic [qacd_pkg::EVENT_W-1:0]  r_ev,  n_ev;
    logic [IW-1:0]                 r_ival, n_ival;

    logic [IW-1:0] ival_inc;
    logic [KW-1:0] key_inc;
    logic          held_en;
    logic          ev_held;

    assign ival_inc = (&r_ival) ? r_ival : r_ival + 1'b1;
    assign key_inc  = (&r_key) ? r_key : r_key + 1'b1;
    assign held_en  = i_cfg.feature_enables[qacd_pkg::FEAT_HELD];
    assign ev_held  = (r_ev == qacd_pkg::EV_HELD) || (r_ev == qacd_pkg::EV_LONG);
    assign o_event  = r_ev;

    always_comb begin
        n_key  = r_key;
        n_dbl  = r_dbl;
        n_ev   = r_ev;
        n_ival = r_ival;
        if (i_tick) begin
            n_ival = ival_inc;
            if (i_cfg.button_present && (ival_inc >= i_cfg.check_interval)) begin
                n_ival = '0;
                if (!i_button_level) begin
                    n_key = key_inc;
                    if (held_en) begin
                        priority if (key_inc > i_cfg.long_hold_checks) begin
                            n_ev = qacd_pkg::EV_LONG;
                        end else if (key_inc > i_cfg.hold_checks) begin
                            n_ev = qacd_pkg::EV_HELD;
                        end
                    end
                end else begin
                    n_key = '0;
                    if (r_key > KW'(1)) begin
                        priority if (ev_held) begin
                            n_ev  = qacd_pkg::EV_RELEASED;
                            n_dbl = '0;
                        end else if (r_dbl > KW'(1)) begin
                            if (r_dbl < i_cfg.double_click_checks) begin
                                n_ev  = qacd_pkg::EV_DOUBLE;
                                n_dbl = '0;
                            end
                        end else begin
                            n_dbl = i_cfg.feature_enables[qacd_pkg::FEAT_DOUBLE]
                                    ? i_cfg.double_click_checks : KW'(1);
                        end
                    end
                end
                // click window runs out
                if (n_dbl != '0) begin
                    if (n_dbl == KW'(1)) n_ev = qacd_pkg::EV_CLICKED;
                    n_dbl = n_dbl - 1'b1;
                end
            end
        end else if (i_take) begin
            if (!ev_held) n_ev = qacd_pkg::EV_OPEN;
        end else if (i_clr_key) begin
            n_key = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_dbl  <= '0;
            r_ev   <= qacd_pkg::EV_OPEN;
            r_ival <= '0;
        end else begin
            r_key  <= n_key;
            r_dbl  <= n_dbl;
            r_ev   <= n_ev;
            r_ival <= n_ival;
        end
    end

endmodule

FILE: bench/qacd_checker.sv
`timescale 1ns / 100ps

module qacd_checker
    import qacd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_in_item          i_in_item,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_out_item         i_out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int CNT_MAX      = (1 << (COUNT_WIDTH_DEF - 1)) - 1;
    localparam int CNT_MIN      = -CNT_MAX - 1;
    localparam int KEY_MAX      = (1 << KEY_W) - 1;
    localparam int INTERVAL_MAX = (1 << INTERVAL_W) - 1;
    localparam int SINGLE_MARK  = 1;

    t_cfg               cfg;
    logic [1:0]         phase_q;
    int                 count_q;
    int                 accel_q;
    logic [EVENT_W-1:0] event_q;
    int                 key_down_q;
    int                 dbl_q;
    int                 interval_q;

    t_out_item          result_q[$];
    t_out_item          want;
    int                 fails;

    function automatic void check_button(bit pressed);
        if (pressed) begin
            if (key_down_q < KEY_MAX) key_down_q++;
            if (key_down_q > cfg.long_hold_checks && cfg.feature_enables[FEAT_HELD]) begin
                event_q = EV_LONG;
            end else if (key_down_q > cfg.hold_checks && cfg.feature_enables[FEAT_HELD]) begin
                event_q = EV_HELD;
            end
        end else begin
            if (key_down_q > 1) begin
                if (event_q == EV_HELD || event_q == EV_LONG) begin
                    event_q = EV_RELEASED;
                    dbl_q = 0;
                end else if (dbl_q > SINGLE_MARK) begin
                    if (dbl_q < cfg.double_click_checks) begin
                        event_q = EV_DOUBLE;
                        dbl_q = 0;
                    end
                end else begin
                    dbl_q = cfg.feature_enables[FEAT_DOUBLE] ?
                            int'(cfg.double_click_checks) : SINGLE_MARK;
                end
            end
            key_down_q = 0;
        end
        if (dbl_q > 0) begin
            dbl_q--;
            if (dbl_q == 0) event_q = EV_CLICKED;
        end
    endfunction

    function automatic void advance_tick(t_in_item it);
        logic [1:0] curr;
        logic [1:0] diff;
        int         inc;
        accel_q = (accel_q < ACCEL_DEC) ? 0 : accel_q - ACCEL_DEC;
        curr = 2'd0;
        if (!it.pin_a) curr = 2'd3;
        if (!it.pin_b) curr = curr ^ 2'd1;
        diff = phase_q - curr;
        inc = cfg.half_step ? ACCEL_RISE / 2 : ACCEL_RISE;
        if (diff[0]) begin
            phase_q = curr;
            if (diff[1]) begin
                if (count_q < CNT_MAX) count_q++;
            end else begin
                if (count_q > CNT_MIN) count_q--;
            end
            if (accel_q <= ACCEL_TOP - inc) accel_q += inc;
        end
        if (interval_q < INTERVAL_MAX) interval_q++;
        if (cfg.button_present && interval_q >= cfg.check_interval) begin
            interval_q = 0;
            check_button(!it.button_level);
        end
    endfunction

    // whole notches out, remainder kept non-negative
    function automatic logic signed [STEP_W-1:0] take_steps();
        int rem;
        int quot;
        int bonus;
        int steps;
        if (cfg.half_step) begin
            rem  = count_q & 1;
            quot = (count_q - rem) / 2;
        end else begin
            rem  = count_q & 3;
            quot = (count_q - rem) / 4;
        end
        count_q = rem;
        bonus = cfg.feature_enables[FEAT_ACCEL] ? (accel_q >> ACCEL_SHIFT) : 0;
        if (quot == 0) return '0;
        key_down_q = 0;
        steps = (quot < 0) ? -(1 + bonus) : 1 + bonus;
        return steps[STEP_W-1:0];
    endfunction

    function automatic t_out_item predict_result(t_in_item it);
        t_out_item r;
        r = '0;
        case (it.opcode)
            OP_TICK:     advance_tick(it);
            OP_TAKE_ROT: r.rotation_steps = take_steps();
            OP_TAKE_BTN: begin
                r.button_event = event_q;
                if (event_q != EV_HELD && event_q != EV_LONG) event_q = EV_OPEN;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_HALF_STEP:    return DATA_W'(cfg.half_step);
            REG_FEATURES:     return DATA_W'(cfg.feature_enables);
            REG_BTN_PRESENT:  return DATA_W'(cfg.button_present);
            REG_CHECK_IVAL:   return DATA_W'(cfg.check_interval);
            REG_HOLD:         return DATA_W'(cfg.hold_checks);
            REG_LONG_HOLD:    return DATA_W'(cfg.long_hold_checks);
            REG_DOUBLE_CLICK: return DATA_W'(cfg.double_click_checks);
            default:          return '0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg        = CFG_RESET;
            phase_q    = 2'd0;
            count_q    = 0;
            accel_q    = 0;
            event_q    = EV_OPEN;
            key_down_q = 0;
            dbl_q      = 0;
            interval_q = 0;
            fails      = 0;
            result_q.delete();
        end else begin
            if (psel && penable && pready && pwrite) begin
                case (paddr[ADDR_W-1:2])
                    REG_HALF_STEP:    cfg.half_step           = pwdata[0];
                    REG_FEATURES:     cfg.feature_enables     = pwdata[2:0];
                    REG_BTN_PRESENT:  cfg.button_present      = pwdata[0];
                    REG_CHECK_IVAL:   cfg.check_interval      = pwdata[INTERVAL_W-1:0];
                    REG_HOLD:         cfg.hold_checks         = pwdata[KEY_W-1:0];
                    REG_LONG_HOLD:    cfg.long_hold_checks    = pwdata[KEY_W-1:0];
                    REG_DOUBLE_CLICK: cfg.double_click_checks = pwdata[KEY_W-1:0];
                    default: ;
                endcase
            end
            if (psel && penable && pready && !pwrite) begin
                if (prdata !== reg_value(paddr[ADDR_W-1:2])) begin
                    $display("%0t: register %0d read, expected %h, got %h", $time,
                             paddr[ADDR_W-1:2], reg_value(paddr[ADDR_W-1:2]), prdata);
                    fails++;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result transaction with none expected, expected nothing, got %h",
                             $time, i_out_item);
                    fails++;
                end else begin
                    want = result_q.pop_front();
                    if (i_out_item.rotation_steps !== want.rotation_steps) begin
                        $display("%0t: rotation_steps, expected %0d, got %0d", $time,
                                 want.rotation_steps, i_out_item.rotation_steps);
                        fails++;
                    end
                    if (i_out_item.button_event !== want.button_event) begin
                        $display("%0t: button_event, expected %0d, got %0d", $time,
                                 want.button_event, i_out_item.button_event);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                result_q.push_back(predict_result(i_in_item));
            end
        end
        o_fail_count <= fails;
        o_pending    <= result_q.size();
    end

endmodule

FILE: bench/quadrature_accel_and_click_detector_tb.sv
`timescale 1ns / 100ps

module quadrature_accel_and_click_detector_tb
    import qacd_pkg::*;
;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RUN_LIMIT_NS = 20_000_000;
    localparam int         RDY_ALWAYS   = 0;
    localparam int         RDY_RANDOM   = 1;
    localparam int         RDY_PERIODIC = 2;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    t_in_item          i_in_item   = '0;
    logic              i_out_ready = 1'b1;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic              o_in_ready;
    logic              o_out_valid;
    t_out_item         o_out_item;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                fail_count;
    int                pending;

    int                ready_mode = RDY_ALWAYS;
    int                ready_tick = 0;
    int                gap_max    = 0;
    int                burst_left = 0;
    int                n_sent     = 0;
    logic [1:0]        enc_pos    = 2'd0;
    logic              btn_lvl    = 1'b1;

    quadrature_accel_and_click_detector u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    qacd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        ready_tick <= ready_tick + 1;
        case (ready_mode)
            RDY_ALWAYS:   i_out_ready <= 1'b1;
            RDY_RANDOM:   i_out_ready <= ($urandom_range(0, 3) != 0);
            RDY_PERIODIC: i_out_ready <= ((ready_tick % 7) > 2);
            default:      i_out_ready <= 1'b1;
        endcase
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    function automatic t_in_item make_item(logic [1:0] op, logic a, logic b, logic btn);
        t_in_item it;
        it.opcode       = op;
        it.pin_a        = a;
        it.pin_b        = b;
        it.button_level = btn;
        return it;
    endfunction

    function automatic t_cfg make_cfg(int hs, int fe, int bp, int ci, int hold,
                                      int lng, int dbl);
        t_cfg c;
        c.half_step           = hs[0];
        c.feature_enables     = fe[2:0];
        c.button_present      = bp[0];
        c.check_interval      = ci[INTERVAL_W-1:0];
        c.hold_checks         = hold[KEY_W-1:0];
        c.long_hold_checks    = lng[KEY_W-1:0];
        c.double_click_checks = dbl[KEY_W-1:0];
        return c;
    endfunction

    // bursts of random length, random gaps between them
    task automatic push_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        burst_left--;
        n_sent++;
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic reg_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input t_cfg c);
        logic [REG_IDX_W-1:0] idx;
        reg_access(1'b1, REG_HALF_STEP,    32'(c.half_step));
        reg_access(1'b1, REG_FEATURES,     32'(c.feature_enables));
        reg_access(1'b1, REG_BTN_PRESENT,  32'(c.button_present));
        reg_access(1'b1, REG_CHECK_IVAL,   32'(c.check_interval));
        reg_access(1'b1, REG_HOLD,         32'(c.hold_checks));
        reg_access(1'b1, REG_LONG_HOLD,    32'(c.long_hold_checks));
        reg_access(1'b1, REG_DOUBLE_CLICK, 32'(c.double_click_checks));
        for (idx = REG_HALF_STEP; idx <= REG_DOUBLE_CLICK; idx++) reg_access(1'b0, idx, 0);
    endtask

    task automatic tick_now();
        logic a;
        logic b;
        a = !(enc_pos == 2'd2 || enc_pos == 2'd3);
        b = (enc_pos == 2'd0 || enc_pos == 2'd3);
        push_item(make_item(OP_TICK, a, b, btn_lvl));
    endtask

    task automatic take_rotation_req();
        push_item(make_item(OP_TAKE_ROT, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1))));
    endtask

    task automatic take_button_req();
        push_item(make_item(OP_TAKE_BTN, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1))));
    endtask

    task automatic turn(input int n, input bit fwd, input bit with_takes);
        repeat (n) begin
            enc_pos = fwd ? enc_pos + 2'd1 : enc_pos - 2'd1;
            tick_now();
            if (with_takes && $urandom_range(0, 15) == 0) take_rotation_req();
        end
    endtask

    task automatic gesture();
        int press_len;
        int release_len;
        press_len   = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(1, 10);
        release_len = $urandom_range(1, 25);
        btn_lvl = 1'b0;
        repeat (press_len) begin
            if ($urandom_range(0, 11) == 0) begin
                turn($urandom_range(2, 8), 1'($urandom_range(0, 1)), 1'b0);
                take_rotation_req();
            end else begin
                tick_now();
            end
        end
        btn_lvl = 1'b1;
        repeat (release_len) tick_now();
        if ($urandom_range(0, 1)) take_button_req();
    endtask

    task automatic noise();
        t_in_item it;
        it = make_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        push_item(it);
        if (it.opcode == OP_TICK) begin
            enc_pos = 2'd0;
            if (!it.pin_a) enc_pos = 2'd3;
            if (!it.pin_b) enc_pos = enc_pos ^ 2'd1;
            btn_lvl = it.button_level;
        end
    endtask

    task automatic random_phase(input int n_items);
        int stop;
        int pick;
        stop = n_sent + n_items;
        while (n_sent < stop) begin
            pick = $urandom_range(0, 19);
            if (pick <= 8) begin
                turn($urandom_range(1, 70), 1'($urandom_range(0, 1)), 1'b1);
            end else if (pick <= 13) begin
                gesture();
            end else if (pick <= 15) begin
                take_rotation_req();
            end else if (pick <= 17) begin
                take_button_req();
            end else begin
                noise();
            end
            if ($urandom_range(0, 59) == 0) wait_results_done();
        end
    endtask

    task automatic set_pace(input int rmode, input int gmax);
        ready_mode = rmode;
        gap_max    = gmax;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: all operations, both turning directions, remainder handling
        set_pace(RDY_ALWAYS, 0);
        take_rotation_req();
        take_button_req();
        push_item(make_item(OP_UNUSED, 1'b1, 1'b1, 1'b1));
        push_item(make_item(OP_UNUSED, 1'b0, 1'b0, 1'b0));
        turn(4, 1'b1, 1'b0);
        take_rotation_req();
        turn(4, 1'b0, 1'b0);
        take_rotation_req();
        turn(2, 1'b1, 1'b0);
        take_rotation_req();
        turn(3, 1'b0, 1'b0);
        take_rotation_req();
        enc_pos = enc_pos + 2'd2;
        tick_now();
        take_rotation_req();
        take_button_req();
        wait_results_done();

        set_pace(RDY_RANDOM, 4);
        random_phase(80);
        wait_results_done();

        apply_config(make_cfg(0, 7, 1, 1, 4, 9, 6));
        set_pace(RDY_PERIODIC, 3);
        random_phase(140);
        wait_results_done();

        apply_config(make_cfg(1, 7, 1, 0, 3, 6, 5));
        set_pace(RDY_RANDOM, 0);
        random_phase(140);
        wait_results_done();

        apply_config(make_cfg(0, 0, 1, 2, 2, 5, 4));
        set_pace(RDY_ALWAYS, 6);
        random_phase(90);
        wait_results_done();

        apply_config(make_cfg(1, $urandom_range(0, 7), 1, 0, 1, 1, 2));
        set_pace(RDY_RANDOM, 2);
        random_phase(90);
        wait_results_done();

        // zero double-click window
        apply_config(make_cfg(0, 7, 1, 0, 5, 10, 0));
        set_pace(RDY_PERIODIC, 0);
        random_phase(80);
        wait_results_done();

        // no button, widest settings; interval counter saturates meanwhile
        apply_config(make_cfg(0, 6, 0, 255, 65535, 65535, 65535));
        set_pace(RDY_RANDOM, 5);
        random_phase(60);
        btn_lvl = 1'b1;
        repeat (200) tick_now();
        wait_results_done();
        reg_access(1'b1, REG_BTN_PRESENT, 1);
        btn_lvl = 1'b0;
        repeat (3) tick_now();
        take_button_req();
        btn_lvl = 1'b1;
        repeat (2) tick_now();
        take_button_req();
        wait_results_done();

        repeat (2) begin
            apply_config(make_cfg($urandom_range(0, 1), $urandom_range(0, 7), 1,
                                  $urandom_range(0, 3), $urandom_range(1, 8),
                                  $urandom_range(1, 16), $urandom_range(0, 10)));
            set_pace($urandom_range(RDY_ALWAYS, RDY_PERIODIC), $urandom_range(0, 4));
            random_phase(70);
            wait_results_done();
        end

        // held and long held while turning, then release
        apply_config(make_cfg(0, 7, 1, 0, 3, 6, 50));
        set_pace(RDY_ALWAYS, 0);
        btn_lvl = 1'b1;
        turn(12, 1'b1, 1'b0);
        take_rotation_req();
        take_button_req();
        btn_lvl = 1'b0;
        turn(12, 1'b0, 1'b0);
        repeat (8) tick_now();
        take_button_req();
        btn_lvl = 1'b1;
        tick_now();
        take_button_req();
        take_rotation_req();
        take_button_req();
        wait_results_done();

        apply_config(CFG_RESET);
        set_pace(RDY_RANDOM, 3);
        random_phase(50);

        wait_results_done();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
